[rtl/tgad_pkg.sv]
package tgad_pkg;

	// One byte of the file as it enters the decoder
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// One decoded result
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  error_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] dest_row;
		logic [15:0] dest_column;
		logic [7:0]  run_length;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        image_done;
	} out_item_t;

	// Parser phase
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PACKET,
		PH_PIXEL,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_TRUNC    = 3'd1;
	localparam logic [2:0] ERR_CMAP     = 3'd2;
	localparam logic [2:0] ERR_TYPE     = 3'd3;
	localparam logic [2:0] ERR_PIXSIZE  = 3'd4;
	localparam logic [2:0] ERR_ZEROSIZE = 3'd5;
	localparam logic [2:0] ERR_OVERRUN  = 3'd6;

	// Header byte offsets
	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_BPP       = 5'd16;
	localparam logic [4:0] HDR_DESC      = 5'd17;

	// Header field values
	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] TYPE_RLE       = 8'd10;
	localparam logic [7:0] BPP_24         = 8'd24;
	localparam logic [7:0] BPP_32         = 8'd32;
	localparam int         DESC_TOP_BIT   = 5;
	localparam int         PKT_RUN_BIT    = 7;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;

endpackage

[rtl/tgad_in_stage.sv]
// Input register: holds one byte until the decoder core takes it.
module tgad_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tgad_pkg::in_item_t  in_data,
	input  logic                advance,
	output logic                item_valid,
	output tgad_pkg::in_item_t  item
);

	logic               valid_s1;
	tgad_pkg::in_item_t data_s1;

	// Free when empty or when the held byte moves on this cycle
	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

[rtl/tgad_core.sv]
// Decoder state and the per-byte step: header parse, ID skip, packets, pixels.
module tgad_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tgad_pkg::in_item_t  item,
	output logic                res_valid,
	output tgad_pkg::out_item_t res
);

	tgad_pkg::phase_t phase_q, phase_n;
	logic [4:0]  hdr_idx_q, hdr_idx_n;
	logic [7:0]  id_skip_q, id_skip_n;
	logic        is_rle_q, is_rle_n;
	logic        four_bpp_q, four_bpp_n;
	logic        bottom_q, bottom_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic [15:0] rows_q, rows_n;
	logic [15:0] col_q, col_n;
	logic [7:0]  pkt_left_q, pkt_left_n;
	logic        pkt_run_q, pkt_run_n;
	logic [23:0] pix_q, pix_n;
	logic [1:0]  pix_idx_q, pix_idx_n;
	logic [2:0]  fault_q, fault_n;

	logic [7:0]  b;
	logic        fin;
	tgad_pkg::phase_t data_phase;
	logic [7:0]  pkt_count;
	logic [16:0] pkt_end;
	logic [23:0] pix_cur;
	logic [1:0]  last_idx;
	logic [7:0]  run_len;
	logic [16:0] col_adv;
	logic [15:0] rows_inc;
	logic [15:0] row_from_bottom;

	assign b          = item.data_byte;
	assign fin        = item.final_byte;
	assign data_phase = is_rle_q ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXEL;
	assign pkt_count  = {1'b0, b[6:0]} + 8'd1;
	assign pkt_end    = {1'b0, col_q} + {9'd0, pkt_count};
	assign last_idx   = four_bpp_q ? 2'd3 : 2'd2;
	assign run_len    = (is_rle_q && pkt_run_q) ? pkt_left_q : 8'd1;
	assign col_adv    = {1'b0, col_q} + {9'd0, run_len};
	assign rows_inc   = rows_q + 16'd1;
	assign row_from_bottom = height_q - 16'd1 - rows_q;

	// Insert the current byte into the BGR assembly word
	always_comb begin
		pix_cur = pix_q;
		case (pix_idx_q)
			2'd0: pix_cur[7:0]   = pix_q[7:0] | b;
			2'd1: pix_cur[15:8]  = pix_q[15:8] | b;
			2'd2: pix_cur[23:16] = pix_q[23:16] | b;
			default: pix_cur = pix_q;
		endcase
	end

	// Next state and result
	always_comb begin
		phase_n    = phase_q;
		hdr_idx_n  = hdr_idx_q;
		id_skip_n  = id_skip_q;
		is_rle_n   = is_rle_q;
		four_bpp_n = four_bpp_q;
		bottom_n   = bottom_q;
		width_n    = width_q;
		height_n   = height_q;
		rows_n     = rows_q;
		col_n      = col_q;
		pkt_left_n = pkt_left_q;
		pkt_run_n  = pkt_run_q;
		pix_n      = pix_q;
		pix_idx_n  = pix_idx_q;
		fault_n    = fault_q;
		res_valid  = 1'b0;
		res        = '0;

		case (phase_q)
			tgad_pkg::PH_HEADER: begin
				// First fault seen wins
				case (hdr_idx_q)
					tgad_pkg::HDR_ID_LEN: begin
						fault_n   = tgad_pkg::ERR_NONE;
						id_skip_n = b;
					end
					tgad_pkg::HDR_CMAP_TYPE: begin
						if (b != 8'd0 && fault_n == tgad_pkg::ERR_NONE)
							fault_n = tgad_pkg::ERR_CMAP;
					end
					tgad_pkg::HDR_IMG_TYPE: begin
						if (b != tgad_pkg::TYPE_TRUECOLOR && b != tgad_pkg::TYPE_RLE &&
							fault_n == tgad_pkg::ERR_NONE)
							fault_n = tgad_pkg::ERR_TYPE;
						is_rle_n = (b == tgad_pkg::TYPE_RLE);
					end
					tgad_pkg::HDR_WIDTH_LO:  width_n[7:0]   = b;
					tgad_pkg::HDR_WIDTH_HI:  width_n[15:8]  = b;
					tgad_pkg::HDR_HEIGHT_LO: height_n[7:0]  = b;
					tgad_pkg::HDR_HEIGHT_HI: height_n[15:8] = b;
					tgad_pkg::HDR_BPP: begin
						if (b != tgad_pkg::BPP_24 && b != tgad_pkg::BPP_32 &&
							fault_n == tgad_pkg::ERR_NONE)
							fault_n = tgad_pkg::ERR_PIXSIZE;
						four_bpp_n = (b == tgad_pkg::BPP_32);
					end
					default: ;
				endcase
				if (hdr_idx_q >= tgad_pkg::HDR_DESC) begin
					bottom_n = ~b[tgad_pkg::DESC_TOP_BIT];
					if ((width_q == 16'd0 || height_q == 16'd0) &&
						fault_n == tgad_pkg::ERR_NONE)
						fault_n = tgad_pkg::ERR_ZEROSIZE;
					hdr_idx_n = 5'd0;
					res_valid = 1'b1;
					if (fault_n != tgad_pkg::ERR_NONE) begin
						res.result_kind = tgad_pkg::KIND_ERROR;
						res.error_code  = fault_n;
						phase_n         = tgad_pkg::PH_ERROR;
					end else begin
						res.result_kind  = tgad_pkg::KIND_HEADER;
						res.image_width  = width_q;
						res.image_height = height_q;
						rows_n     = 16'd0;
						col_n      = 16'd0;
						pix_n      = 24'd0;
						pix_idx_n  = 2'd0;
						pkt_left_n = 8'd0;
						pkt_run_n  = 1'b0;
						phase_n    = (id_skip_q != 8'd0) ? tgad_pkg::PH_SKIP : data_phase;
					end
				end else begin
					hdr_idx_n = hdr_idx_q + 5'd1;
				end
			end
			tgad_pkg::PH_SKIP: begin
				id_skip_n = id_skip_q - 8'd1;
				if (id_skip_n == 8'd0)
					phase_n = data_phase;
			end
			tgad_pkg::PH_PACKET: begin
				// A packet must not run past the end of the row
				if (pkt_end > {1'b0, width_q}) begin
					res_valid       = 1'b1;
					res.result_kind = tgad_pkg::KIND_ERROR;
					res.error_code  = tgad_pkg::ERR_OVERRUN;
					phase_n         = tgad_pkg::PH_ERROR;
				end else begin
					pkt_left_n = pkt_count;
					pkt_run_n  = b[tgad_pkg::PKT_RUN_BIT];
					pix_n      = 24'd0;
					pix_idx_n  = 2'd0;
					phase_n    = tgad_pkg::PH_PIXEL;
				end
			end
			tgad_pkg::PH_PIXEL: begin
				if (pix_idx_q >= last_idx) begin
					res_valid       = 1'b1;
					res.result_kind = tgad_pkg::KIND_PIXEL;
					res.red         = four_bpp_q ? pix_cur[23:16] : b;
					res.green       = pix_cur[15:8];
					res.blue        = pix_cur[7:0];
					res.alpha       = four_bpp_q ? b : tgad_pkg::ALPHA_OPAQUE;
					res.dest_row    = bottom_q ? row_from_bottom : rows_q;
					res.dest_column = col_q;
					res.run_length  = run_len;
					// Advance position; wrap to the next row at the row end
					if (col_adv >= {1'b0, width_q}) begin
						col_n  = 16'd0;
						rows_n = rows_inc;
						if (rows_inc >= height_q) begin
							phase_n        = tgad_pkg::PH_DONE;
							res.image_done = 1'b1;
						end
					end else begin
						col_n = col_adv[15:0];
					end
					pix_n     = 24'd0;
					pix_idx_n = 2'd0;
					if (is_rle_q && !res.image_done) begin
						if (pkt_run_q || pkt_left_q <= 8'd1) begin
							pkt_left_n = 8'd0;
							phase_n    = tgad_pkg::PH_PACKET;
						end else begin
							pkt_left_n = pkt_left_q - 8'd1;
						end
					end
				end else begin
					pix_n     = pix_cur;
					pix_idx_n = pix_idx_q + 2'd1;
				end
			end
			default: ;
		endcase

		// Last byte of the file: flag early end, then rearm
		if (fin) begin
			if (phase_n != tgad_pkg::PH_DONE && phase_n != tgad_pkg::PH_ERROR) begin
				res_valid       = 1'b1;
				res             = '0;
				res.result_kind = tgad_pkg::KIND_ERROR;
				res.error_code  = tgad_pkg::ERR_TRUNC;
			end
			phase_n    = tgad_pkg::PH_HEADER;
			hdr_idx_n  = 5'd0;
			id_skip_n  = 8'd0;
			is_rle_n   = 1'b0;
			four_bpp_n = 1'b0;
			bottom_n   = 1'b0;
			width_n    = 16'd0;
			height_n   = 16'd0;
			rows_n     = 16'd0;
			col_n      = 16'd0;
			pkt_left_n = 8'd0;
			pkt_run_n  = 1'b0;
			pix_n      = 24'd0;
			pix_idx_n  = 2'd0;
			fault_n    = tgad_pkg::ERR_NONE;
		end

		if (!step)
			res_valid = 1'b0;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tgad_pkg::PH_HEADER;
			hdr_idx_q  <= 5'd0;
			id_skip_q  <= 8'd0;
			is_rle_q   <= 1'b0;
			four_bpp_q <= 1'b0;
			bottom_q   <= 1'b0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			rows_q     <= 16'd0;
			col_q      <= 16'd0;
			pkt_left_q <= 8'd0;
			pkt_run_q  <= 1'b0;
			pix_q      <= 24'd0;
			pix_idx_q  <= 2'd0;
			fault_q    <= tgad_pkg::ERR_NONE;
		end else if (step) begin
			phase_q    <= phase_n;
			hdr_idx_q  <= hdr_idx_n;
			id_skip_q  <= id_skip_n;
			is_rle_q   <= is_rle_n;
			four_bpp_q <= four_bpp_n;
			bottom_q   <= bottom_n;
			width_q    <= width_n;
			height_q   <= height_n;
			rows_q     <= rows_n;
			col_q      <= col_n;
			pkt_left_q <= pkt_left_n;
			pkt_run_q  <= pkt_run_n;
			pix_q      <= pix_n;
			pix_idx_q  <= pix_idx_n;
			fault_q    <= fault_n;
		end
	end

endmodule

[rtl/tgad_out_stage.sv]
// Result register: holds a result until the consumer takes it.
module tgad_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  tgad_pkg::out_item_t res,
	output logic                slot_free,
	output logic                out_valid,
	input  logic                out_ready,
	output tgad_pkg::out_item_t out_data
);

	logic                valid_s2;
	tgad_pkg::out_item_t data_s2;

	// The slot frees up when empty or when its result transfers this cycle
	assign slot_free = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (slot_free) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			data_s2 <= res;
		end
	end

endmodule

[rtl/tga_rle_truecolor_decoder_top.sv]
// TGA true-color decoder, uncompressed and RLE, 24 or 32 bits per pixel. Feed the file one
// byte per transfer, with final_byte set on its last byte; the decoder then rearms for the
// next file. It returns one header result, then one result per pixel (or per RLE run, with
// run_length) carrying RGBA and the destination row and first column in a top-down image,
// or an error result, after which bytes are ignored until final_byte. Throughput is one
// byte per cycle while the result slot is free: each byte updates the parser state
// combinationally between the input register and the result register, which registers
// any result it yields. A byte that yields no result still takes its own step.
module tga_rle_truecolor_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tgad_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tgad_pkg::out_item_t out_data
);

	logic                item_valid;
	tgad_pkg::in_item_t  item;
	logic                slot_free;
	logic                step;
	logic                res_valid;
	tgad_pkg::out_item_t res;

	// A byte is processed when the result slot can take whatever it produces
	assign step = item_valid && slot_free;

	tgad_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.advance    (slot_free),
		.item_valid (item_valid),
		.item       (item)
	);

	tgad_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	tgad_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Results only come from a byte being processed
	a_res_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step)
		else $error("core result without a processed byte");

	// Input stalls only while a byte is held
	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> item_valid)
		else $error("input stalled with empty input register");

	// Error results always carry a code
	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.result_kind == tgad_pkg::KIND_ERROR)
			|-> out_data.error_code != tgad_pkg::ERR_NONE)
		else $error("error result without error code");

	// Pixel results cover at least one pixel
	a_pix_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.result_kind == tgad_pkg::KIND_PIXEL)
			|-> out_data.run_length != 8'd0)
		else $error("pixel result with zero run length");

endmodule
